// ===== rtl/core/qrcrc_pkg.sv =====
// Shared constants, types and functions for the payload CRC trailer checker.
`default_nettype none

package qrcrc_pkg;

  // CRC-16/CCITT-FALSE parameters
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // "6304" as four ASCII bytes, first character in the top byte
  localparam logic [31:0] MARKER_TEXT = 32'h3633_3034;

  // ASCII offsets for uppercase hex digits
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_ALPHA_0 = 8'h37;  // 'A' - 10
  localparam logic [3:0] HEX_TEN       = 4'd10;

  // Result status codes
  localparam logic [1:0] STATUS_VALID      = 2'd0;
  localparam logic [1:0] STATUS_SHORT      = 2'd1;
  localparam logic [1:0] STATUS_NO_MARKER  = 2'd2;
  localparam logic [1:0] STATUS_MISMATCH   = 2'd3;

  // Default depth of the check request queue
  localparam int QRCRC_QUEUE_DEPTH = 2;

  // Check request handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  kind;     // STATUS_VALID here means "compare the trailer"
    logic [31:0] trailer;  // last four characters, first in the top byte
    logic [15:0] crc;      // CRC through the marker, zero when not compared
  } check_req_t;

  // One byte folded into the CRC, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Nibble to uppercase ASCII hex digit
  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    if (nib < HEX_TEN) begin
      return ASCII_ZERO + {4'h0, nib};
    end else begin
      return ASCII_ALPHA_0 + {4'h0, nib};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qrcrc_if.sv =====
// Stream interfaces for payload bytes and check results.
`default_nettype none

interface qrcrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface qrcrc_status_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] computed_crc;

  modport source (output valid, output status, output computed_crc, input ready);
  modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qrcrc_front.sv =====
// Front end: absorbs bytes, keeps CRC, history and window, classifies the final byte.
`default_nettype none

module qrcrc_front
  import qrcrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output check_req_t      req
);

  localparam logic [3:0] LEN_FULL = 4'd8;

  logic [15:0] running_crc;
  logic [15:0] crc_history [4];
  logic [7:0]  byte_window [8];
  logic [3:0]  length_seen;

  logic [7:0]  window_next [8];
  logic [3:0]  length_next;
  logic [15:0] crc_next;
  logic [31:0] head;
  logic [31:0] tail;

  // Next state of the byte path
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      window_next[k] = byte_window[k + 1];
    end
    window_next[7] = data_byte;
    length_next = (length_seen < LEN_FULL) ? length_seen + 4'd1 : length_seen;
    crc_next    = crc_fold(running_crc, data_byte);
    head = {window_next[0], window_next[1], window_next[2], window_next[3]};
    tail = {window_next[4], window_next[5], window_next[6], window_next[7]};
  end

  // Classify the payload on its final byte
  always_comb begin
    req.trailer = tail;
    req.crc     = 16'h0000;
    if (length_next != LEN_FULL) begin
      req.kind = STATUS_SHORT;
    end else if (head != MARKER_TEXT || tail == MARKER_TEXT) begin
      req.kind = STATUS_NO_MARKER;
    end else begin
      req.kind = STATUS_VALID;
      // CRC before the fourth-last byte, i.e. through the marker
      req.crc  = crc_history[2];
    end
  end

  // State registers, back to reset values after each final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      running_crc <= CRC_INIT;
      length_seen <= 4'd0;
      for (int k = 0; k < 4; k++) begin
        crc_history[k] <= CRC_INIT;
      end
      for (int k = 0; k < 8; k++) begin
        byte_window[k] <= 8'h00;
      end
    end else if (accept) begin
      running_crc    <= crc_next;
      length_seen    <= length_next;
      crc_history[0] <= running_crc;
      for (int k = 1; k < 4; k++) begin
        crc_history[k] <= crc_history[k - 1];
      end
      for (int k = 0; k < 8; k++) begin
        byte_window[k] <= window_next[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> running_crc == CRC_INIT && length_seen == 4'd0)
    else $error("front state not cleared after final byte");

  a_crc_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !last |=> running_crc == crc_fold($past(running_crc), $past(data_byte)))
    else $error("running CRC did not advance by one byte");

  a_length_saturates: assert property (@(posedge clk) disable iff (rst)
    length_seen <= LEN_FULL)
    else $error("byte count ran past its saturation value");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qrcrc_queue.sv =====
// Small queue of check requests between the front and back ends.
`default_nettype none

module qrcrc_queue
  import qrcrc_pkg::*;
#(
  parameter int DEPTH = QRCRC_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire check_req_t push_data,
  input  wire logic       pop,
  output check_req_t      pop_data,
  output logic            full,
  output logic            empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  check_req_t       entry [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entry[rd_ptr];

  // Storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("request popped from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qrcrc_back.sv =====
// Back end: compares the trailer with the hex CRC and holds the result register.
`default_nettype none

module qrcrc_back
  import qrcrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_avail,
  input  wire check_req_t req,
  output logic            req_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [15:0]     computed_crc
);

  logic [31:0] expected;
  logic [1:0]  status_next;

  // Uppercase hex of the CRC, most significant nibble first
  always_comb begin
    expected = {hex_upper(req.crc[15:12]), hex_upper(req.crc[11:8]),
                hex_upper(req.crc[7:4]),   hex_upper(req.crc[3:0])};
    if (req.kind == STATUS_VALID) begin
      status_next = (req.trailer == expected) ? STATUS_VALID : STATUS_MISMATCH;
    end else begin
      status_next = req.kind;
    end
  end

  // Take a request whenever the result register is free or draining
  assign req_take = req_avail && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      status       <= status_next;
      computed_crc <= req.crc;
    end
  end

`ifndef SYNTHESIS
  a_crc_zero_unchecked: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_SHORT || status == STATUS_NO_MARKER)
      |-> computed_crc == 16'h0000)
    else $error("CRC reported for an unchecked payload");

  a_take_needs_request: assert property (@(posedge clk) disable iff (rst)
    req_take |-> req_avail)
    else $error("request taken from an empty queue");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready
      |=> out_valid && $stable(status) && $stable(computed_crc))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qr_payload_crc_trailer_check_top.sv =====
// Top level of the payload CRC-16 trailer checker.
//
//   port       dir   request contents              notes
//   byte_ch    in    data_byte[7:0], last          one payload character
//   status_ch  out   status[1:0], computed_crc     one result per final byte
//
// One byte is taken every cycle while the request queue is not full; the CRC
// fold of a byte is combinational and registered when the byte is accepted.
// A result's request enters the queue when its final byte is accepted and
// moves into the result register when that register is free or draining.
// byte_ch stalls only on a full request queue, which at the default depth
// happens only if status_ch holds results back. Reset (rst, synchronous) empties
// the queue and returns the CRC, history, window and count to their start values.
`default_nettype none

module qr_payload_crc_trailer_check_top
  import qrcrc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QRCRC_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  qrcrc_byte_if.sink      byte_ch,
  qrcrc_status_if.source  status_ch
);

  check_req_t front_req;
  check_req_t back_req;
  logic       q_full;
  logic       q_empty;
  logic       accept;
  logic       push;
  logic       pop;

  // Input handshake: stall only on a full queue
  assign byte_ch.ready = !q_full;
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign push          = accept && byte_ch.last;

  qrcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (byte_ch.data_byte),
    .last      (byte_ch.last),
    .req       (front_req)
  );

  qrcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_req),
    .pop       (pop),
    .pop_data  (back_req),
    .full      (q_full),
    .empty     (q_empty)
  );

  qrcrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .req_avail    (!q_empty),
    .req          (back_req),
    .req_take     (pop),
    .out_valid    (status_ch.valid),
    .out_ready    (status_ch.ready),
    .status       (status_ch.status),
    .computed_crc (status_ch.computed_crc)
  );

endmodule

`default_nettype wire
